[rtl/mec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the Mandelbrot escape-time counter.
// No dependencies; every other file of the block imports this package.
package mec_pkg;

    // Width of one input coordinate (signed fixed point).
    localparam int IN_WIDTH = 30;
    // Width of the iteration counter and of the limit register.
    localparam int COUNT_WIDTH = 8;
    // Products are carried modulo 2^64.
    localparam int ACC_WIDTH = 64;
    // Bits of the multiplier operand handled by one cell.
    localparam int DIGIT_W = 16;
    // Limit loaded at reset.
    localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = 8'd14;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LAUNCH,
        S_WAIT,
        S_DONE
    } t_state;

    // Partial sums of the three products that travel along the cell chain.
    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] rr;
        logic signed [ACC_WIDTH-1:0] ii;
        logic signed [ACC_WIDTH-1:0] ri;
    } t_prod;

    // Strobes decoded from the sequencer state.
    typedef struct packed {
        logic accept;
        logic launch;
        logic update;
        logic load_out;
    } t_ctrl;

endpackage
`default_nettype wire

[rtl/mec_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Top level of the Mandelbrot escape-time counter: sequencer, z registers,
// multiplier cell chain, round update and output register. Uses mec_pkg,
// mec_cell and mec_step.
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  ------------------------------------
//  in       to block   i_in_valid/o_in_stall  i_c_real, i_c_imag
//  out      from block o_out_valid/i_out_stall o_iteration_count, o_inside_set
//  cfg      to block   i_cfg_valid/o_cfg_ready i_cfg_data (max_iterations)
//
// One point at a time. A round is one launch plus a pass along the multiplier
// chain (NCELL = ceil(max(WORD_WIDTH,30)/16) cells, two at the default width);
// the chain's length sets the round time. A point ends when it reaches the
// limit or escapes. The reset is synchronous and clears the sequencer, the chain
// valids and the output valid and loads the limit 14. The next point is accepted
// while a result waits in the output register; a finished point waits in its own
// state until that register is free.
module mandelbrot_escape_count_top #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 27
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_stall,
    input  wire logic signed [mec_pkg::IN_WIDTH-1:0]      i_c_real,
    input  wire logic signed [mec_pkg::IN_WIDTH-1:0]      i_c_imag,
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_stall,
    output logic             [mec_pkg::COUNT_WIDTH-1:0]   o_iteration_count,
    output logic                                          o_inside_set,
    input  wire logic                                     i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  wire logic        [mec_pkg::COUNT_WIDTH-1:0]   i_cfg_data
);
    import mec_pkg::*;

    localparam int ZW    = (WORD_WIDTH > IN_WIDTH) ? WORD_WIDTH : IN_WIDTH;
    localparam int NCELL = (ZW + DIGIT_W - 1) / DIGIT_W;

    t_state                    r_state;
    t_state                    n_state;
    t_ctrl                     w_ctrl;
    logic [COUNT_WIDTH-1:0]    r_max_iter;
    logic [COUNT_WIDTH-1:0]    r_count;
    logic signed [ZW-1:0]      r_zr;
    logic signed [ZW-1:0]      r_zi;
    logic signed [IN_WIDTH-1:0] r_c_real;
    logic signed [IN_WIDTH-1:0] r_c_imag;
    logic                      r_out_valid;
    logic [COUNT_WIDTH-1:0]    r_out_count;
    logic                      r_out_inside;
    logic                      w_out_free;
    logic                      w_below_limit;
    logic [NCELL:0]            w_valid;
    t_prod                     w_prod [0:NCELL];
    logic                      w_escape;
    logic signed [ZW-1:0]      w_next_zr;
    logic signed [ZW-1:0]      w_next_zi;

    // Configuration port is always ready; the limit register takes the data.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_iter <= i_cfg_data;
        end
    end

    assign w_out_free    = !r_out_valid || !i_out_stall;
    assign w_below_limit = (r_count < r_max_iter);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LAUNCH;
                end
            end
            S_LAUNCH: begin
                n_state = w_below_limit ? S_WAIT : S_DONE;
            end
            S_WAIT: begin
                if (w_valid[NCELL]) begin
                    n_state = w_escape ? S_DONE : S_LAUNCH;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        w_ctrl = '0;
        case (r_state)
            S_IDLE: begin
                w_ctrl.accept = i_in_valid;
            end
            S_LAUNCH: begin
                w_ctrl.launch = w_below_limit;
            end
            S_WAIT: begin
                w_ctrl.update = w_valid[NCELL] && !w_escape;
            end
            S_DONE: begin
                w_ctrl.load_out = w_out_free;
            end
            default: begin
                w_ctrl = '0;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Point and z registers; z is held steady while the chain works on it.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.accept) begin
            r_c_real <= i_c_real;
            r_c_imag <= i_c_imag;
            r_zr     <= ZW'(i_c_real);
            r_zi     <= ZW'(i_c_imag);
            r_count  <= '0;
        end else if (w_ctrl.update) begin
            r_zr    <= w_next_zr;
            r_zi    <= w_next_zi;
            r_count <= r_count + 1'b1;
        end
    end

    // Multiplier chain: one cell per 16-bit digit of z.
    assign w_valid[0] = w_ctrl.launch;
    assign w_prod[0]  = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        mec_cell #(
            .ZW    (ZW),
            .INDEX (k),
            .NCELL (NCELL)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_zr    (r_zr),
            .i_zi    (r_zi),
            .i_prod  (w_prod[k]),
            .o_valid (w_valid[k+1]),
            .o_prod  (w_prod[k+1])
        );
    end

    // Escape test and next z from the finished products.
    mec_step #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .ZW         (ZW)
    ) u_step (
        .i_prod   (w_prod[NCELL]),
        .i_c_real (r_c_real),
        .i_c_imag (r_c_imag),
        .o_escape (w_escape),
        .o_zr     (w_next_zr),
        .o_zi     (w_next_zi)
    );

    // Output register; it is loaded from the done state once it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_ctrl.load_out) begin
            r_out_count  <= r_count;
            r_out_inside <= (r_count == r_max_iter);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_iteration_count = r_out_count;
    assign o_inside_set      = r_out_inside;

    // At most one round is in flight along the chain.
    a_one_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_valid))
        else $error("more than one round in the multiplier chain");

    // Finished products only arrive while the sequencer waits for them.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[NCELL] |-> r_state == S_WAIT)
        else $error("chain result outside the wait state");

    // A finished round either starts the next one or ends the point.
    a_round_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) && w_valid[NCELL] |=> (r_state == S_LAUNCH) || (r_state == S_DONE))
        else $error("bad exit from the wait state");

    // A result leaving the done state lands in the output register.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.load_out |=> o_out_valid && (r_state == S_IDLE))
        else $error("result not loaded into the output register");

    // No new round starts while the chain is still busy.
    a_launch_idle_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.launch |-> (w_valid[NCELL:1] == '0))
        else $error("round launched into a busy chain");

endmodule
`default_nettype wire

[rtl/mec_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// One cell of the multiplier chain: adds the partial products of its own
// 16-bit digit of z to the running sums and hands them on. Uses mec_pkg.
module mec_cell #(
    parameter int ZW    = 32,
    parameter int INDEX = 0,
    parameter int NCELL = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic signed [ZW-1:0] i_zr,
    input  wire logic signed [ZW-1:0] i_zi,
    input  wire mec_pkg::t_prod       i_prod,
    output logic                      o_valid,
    output mec_pkg::t_prod            o_prod
);
    import mec_pkg::*;

    localparam int PAD_W = NCELL * DIGIT_W;
    localparam int PW    = ZW + DIGIT_W + 1;
    localparam int SHIFT = INDEX * DIGIT_W;

    logic signed [PAD_W-1:0]     w_pad_r;
    logic signed [PAD_W-1:0]     w_pad_i;
    logic        [DIGIT_W-1:0]   w_slice_r;
    logic        [DIGIT_W-1:0]   w_slice_i;
    logic signed [DIGIT_W:0]     w_d_r;
    logic signed [DIGIT_W:0]     w_d_i;
    logic signed [PW-1:0]        w_p_rr;
    logic signed [PW-1:0]        w_p_ii;
    logic signed [PW-1:0]        w_p_ri;
    logic signed [ACC_WIDTH-1:0] w_t_rr;
    logic signed [ACC_WIDTH-1:0] w_t_ii;
    logic signed [ACC_WIDTH-1:0] w_t_ri;
    t_prod                       n_prod;
    t_prod                       r_prod;
    logic                        r_valid;

    // Pick this cell's digit; only the top digit carries the sign.
    assign w_pad_r   = PAD_W'(i_zr);
    assign w_pad_i   = PAD_W'(i_zi);
    assign w_slice_r = w_pad_r[SHIFT +: DIGIT_W];
    assign w_slice_i = w_pad_i[SHIFT +: DIGIT_W];
    assign w_d_r = (INDEX == NCELL - 1) ? {w_slice_r[DIGIT_W-1], w_slice_r}
                                        : {1'b0, w_slice_r};
    assign w_d_i = (INDEX == NCELL - 1) ? {w_slice_i[DIGIT_W-1], w_slice_i}
                                        : {1'b0, w_slice_i};

    // Partial products of zr*zr, zi*zi and zr*zi for this digit.
    assign w_p_rr = i_zr * w_d_r;
    assign w_p_ii = i_zi * w_d_i;
    assign w_p_ri = i_zr * w_d_i;

    // Weight each partial product by the digit position, modulo 2^64.
    assign w_t_rr = ACC_WIDTH'(w_p_rr) << SHIFT;
    assign w_t_ii = ACC_WIDTH'(w_p_ii) << SHIFT;
    assign w_t_ri = ACC_WIDTH'(w_p_ri) << SHIFT;

    // Accumulate onto the sums handed in by the previous cell.
    always_comb begin
        n_prod.rr = i_prod.rr + w_t_rr;
        n_prod.ii = i_prod.ii + w_t_ii;
        n_prod.ri = i_prod.ri + w_t_ri;
    end

    // Valid travels with the sums; the sums themselves need no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_prod <= n_prod;
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule
`default_nettype wire

[rtl/mec_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// Round update: rescales the finished products, tests the escape bound and
// forms the next z. Combinational; uses mec_pkg.
module mec_step #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 27,
    parameter int ZW         = 32
) (
    input  wire mec_pkg::t_prod                       i_prod,
    input  wire logic signed [mec_pkg::IN_WIDTH-1:0]  i_c_real,
    input  wire logic signed [mec_pkg::IN_WIDTH-1:0]  i_c_imag,
    output logic                                      o_escape,
    output logic signed [ZW-1:0]                      o_zr,
    output logic signed [ZW-1:0]                      o_zi
);
    import mec_pkg::*;

    localparam logic signed [ACC_WIDTH-1:0] FOUR = 64'sd4 <<< FRAC_BITS;

    logic signed [ACC_WIDTH-1:0]  w_zr2;
    logic signed [ACC_WIDTH-1:0]  w_zi2;
    logic signed [ACC_WIDTH-1:0]  w_cross;
    logic signed [ACC_WIDTH-1:0]  w_mag;
    logic signed [ACC_WIDTH-1:0]  w_sum_r;
    logic signed [ACC_WIDTH-1:0]  w_sum_i;
    logic signed [WORD_WIDTH-1:0] w_wrap_r;
    logic signed [WORD_WIDTH-1:0] w_wrap_i;

    // Drop the fraction bits; the cross term keeps one extra bit for the factor 2.
    assign w_zr2   = $signed(i_prod.rr) >>> FRAC_BITS;
    assign w_zi2   = $signed(i_prod.ii) >>> FRAC_BITS;
    assign w_cross = $signed(i_prod.ri) >>> (FRAC_BITS - 1);

    // Escape when the magnitude squared exceeds four.
    assign w_mag    = w_zr2 + w_zi2;
    assign o_escape = (w_mag > FOUR);

    // Next z, wrapped to the word width and extended back to the z register.
    assign w_sum_r  = w_zr2 - w_zi2 + ACC_WIDTH'(i_c_real);
    assign w_sum_i  = w_cross + ACC_WIDTH'(i_c_imag);
    assign w_wrap_r = w_sum_r[WORD_WIDTH-1:0];
    assign w_wrap_i = w_sum_i[WORD_WIDTH-1:0];
    assign o_zr     = ZW'(w_wrap_r);
    assign o_zi     = ZW'(w_wrap_i);

endmodule
`default_nettype wire
